// ===== sv/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define BBR_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked check that also runs across reset
`define BBR_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/bbr_pkg.sv =====
// shared types, constants and helpers of the 5x5 box blur
`timescale 1ns / 1ps
package bbr_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int CH_W          = 8;
    localparam int PIX_W         = 3 * CH_W;
    localparam int ROW_W         = 12;
    localparam int CFG_W         = 12;
    localparam int CRD_W         = 14;
    localparam int SW            = CRD_W + 2;
    localparam int SLOTS         = 4;
    localparam int LINE_W        = SLOTS * PIX_W;
    localparam int KSIZE         = 5;
    localparam int KHALF         = 2;
    localparam int MIN_DIM       = 3;
    localparam int SUM5_W        = 11;
    localparam int SUM25_W       = 13;
    localparam int RECIP_W       = 13;
    localparam int RECIP         = 5243;
    localparam int RECIP_SHIFT   = 17;
    localparam int PROD_W        = SUM25_W + RECIP_W;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int CNT_W         = $clog2(FIFO_DEPTH + 1) + 1;
    localparam int RST_WIDTH     = 640;
    localparam int RST_HEIGHT    = 480;

    // register indexes of the configuration port
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [PIX_W-1:0] t_pix;
    // window: [row][col], row 4 and col 4 are the newest
    typedef t_pix [KSIZE-1:0][KSIZE-1:0] t_win;
    typedef logic signed [SW-1:0] t_spos;

    // one filter job, handed from the front end to the result sequencer
    typedef struct packed {
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row_last;
        logic [CRD_W-1:0] col_last;
    } t_job;

    localparam t_spos WIN_LAST = t_spos'(KSIZE - 1);

    // clamp a position to the image, then map it to a window index
    function automatic logic [2:0] win_idx(input t_spos pos, input t_spos last,
                                          input t_spos base);
        t_spos t;
        t_spos w;
        t = pos;
        if (t < 0) t = '0;
        else if (t > last) t = last;
        w = t - base + WIN_LAST;
        if (w < 0) w = '0;
        else if (w > WIN_LAST) w = WIN_LAST;
        return w[2:0];
    endfunction

    function automatic t_spos to_spos(input logic [CRD_W-1:0] v);
        return $signed({2'b00, v});
    endfunction

endpackage

// ===== sv/bbr_line_mem.sv =====
// line store: one word per column holding four rows of pixels
`timescale 1ns / 1ps
module bbr_line_mem #(
    parameter int DEPTH = bbr_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = bbr_pkg::LINE_W
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bbr_front.sv =====
// input side: position counters, line store read-modify-write, window shift
`timescale 1ns / 1ps
module bbr_front #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bbr_pkg::t_pix                 i_pix,
    input  logic [bbr_pkg::CRD_W-1:0]     i_w_eff,
    input  logic [bbr_pkg::CRD_W-1:0]     i_h_eff,
    input  logic                          i_gen_ready,
    output bbr_pkg::t_win                 o_win,
    output bbr_pkg::t_job                 o_job,
    output logic                          o_job_load
);

    localparam int CW = bbr_pkg::CRD_W;
    localparam int RW = bbr_pkg::ROW_W;
    localparam int PW = bbr_pkg::PIX_W;

    logic [COL_W-1:0] r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    logic [COL_W-1:0] c_sat;
    logic [RW-1:0]    r_sat;
    logic [CW-1:0]    w_last, h_last;
    logic             accept, fire;

    logic             r_s1_valid;
    bbr_pkg::t_pix    r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    logic [RW-1:0]    r_s1_row;
    logic [CW-1:0]    r_s1_wlast, r_s1_hlast;

    logic [bbr_pkg::LINE_W-1:0] rd_word, wr_word;
    bbr_pkg::t_pix [bbr_pkg::KSIZE-1:0] new_col;
    bbr_pkg::t_win r_win;

    // saturate the counters to the current geometry
    always_comb begin
        w_last = i_w_eff - CW'(1);
        h_last = i_h_eff - CW'(1);
        c_sat  = (CW'(r_col) > w_last) ? w_last[COL_W-1:0] : r_col;
        r_sat  = (CW'(r_row) > h_last) ? h_last[RW-1:0] : r_row;
    end

    assign fire       = r_s1_valid && i_gen_ready;
    assign o_in_stall = r_s1_valid && !i_gen_ready;
    assign accept     = i_in_valid && !o_in_stall;

    // next position in raster order
    always_comb begin
        n_col = c_sat + COL_W'(1);
        n_row = r_sat;
        if (CW'(c_sat) == w_last) begin
            n_col = '0;
            n_row = (CW'(r_sat) == h_last) ? '0 : r_sat + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // item held while the line word is read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix   <= i_pix;
            r_s1_col   <= c_sat;
            r_s1_row   <= r_sat;
            r_s1_wlast <= w_last;
            r_s1_hlast <= h_last;
        end
    end

    // write back the line word with this row's slot replaced
    always_comb begin
        wr_word = rd_word;
        wr_word[r_s1_row[1:0]*PW +: PW] = r_s1_pix;
    end

    bbr_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W),
        .DW    (bbr_pkg::LINE_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (fire),
        .i_waddr (r_s1_col),
        .i_wdata (wr_word),
        .i_re    (accept),
        .i_raddr (c_sat),
        .o_rdata (rd_word)
    );

    // new right-hand column of the window, rows above the image read zero
    always_comb begin
        logic [1:0] slot;
        for (int k = 0; k < bbr_pkg::SLOTS; k++) begin
            slot = r_s1_row[1:0] + 2'(k);
            if ((RW+1)'(r_s1_row) + (RW+1)'(k) >= (RW+1)'(bbr_pkg::SLOTS)) begin
                new_col[k] = rd_word[slot*PW +: PW];
            end else begin
                new_col[k] = '0;
            end
        end
        new_col[bbr_pkg::KSIZE-1] = r_s1_pix;
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (fire) begin
            for (int k = 0; k < bbr_pkg::KSIZE; k++) begin
                for (int j = 0; j < bbr_pkg::KSIZE - 1; j++) begin
                    r_win[k][j] <= r_win[k][j+1];
                end
                r_win[k][bbr_pkg::KSIZE-1] <= new_col[k];
            end
        end
    end

    assign o_win = r_win;

    // a job exists once two rows and two columns lie behind the item
    always_comb begin
        o_job.row      = CW'(r_s1_row);
        o_job.col      = CW'(r_s1_col);
        o_job.row_last = r_s1_hlast;
        o_job.col_last = r_s1_wlast;
        o_job_load     = fire && (r_s1_row >= RW'(bbr_pkg::KHALF))
                              && (r_s1_col >= COL_W'(bbr_pkg::KHALF));
    end

endmodule

// ===== sv/bbr_gen.sv =====
// result sequencer: walks the released positions, sums, divides, queues
`timescale 1ns / 1ps
module bbr_gen #(
    parameter int COL_W = $clog2(bbr_pkg::MAX_WIDTH_DEF)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bbr_pkg::t_win              i_win,
    input  bbr_pkg::t_job              i_job,
    input  logic                       i_job_load,
    output logic                       o_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [bbr_pkg::CH_W-1:0]   o_red_out,
    output logic [bbr_pkg::CH_W-1:0]   o_green_out,
    output logic [bbr_pkg::CH_W-1:0]   o_blue_out,
    output logic [bbr_pkg::ROW_W-1:0]  o_out_row,
    output logic [COL_W-1:0]           o_out_col,
    output logic                       o_run_last
);

    localparam int CW = bbr_pkg::CRD_W;
    localparam int K  = bbr_pkg::KSIZE;
    localparam int CH = bbr_pkg::CH_W;

    typedef struct packed {
        logic [CH-1:0]               red;
        logic [CH-1:0]               green;
        logic [CH-1:0]               blue;
        logic [bbr_pkg::ROW_W-1:0]   row;
        logic [COL_W-1:0]            col;
        logic                        last;
    } t_res;

    logic          r_active;
    bbr_pkg::t_job r_job;
    logic [CW-1:0] r_pos_r, r_pos_c;
    logic [CW-1:0] row_end, col_end;
    logic          issue, last_issue;

    logic [bbr_pkg::CNT_W-1:0] r_cnt;
    logic [bbr_pkg::FIFO_AW-1:0] r_wp, r_rp;
    t_res          r_fifo [bbr_pkg::FIFO_DEPTH];
    logic          push, pop;

    logic [2:0]    wi [K];
    logic [2:0]    wj [K];
    logic [bbr_pkg::SUM5_W-1:0] n_a_sum [K][3];
    logic [bbr_pkg::SUM5_W-1:0] r_a_sum [K][3];
    logic          r_a_valid, r_a_last;
    logic [CW-1:0] r_a_row, r_a_col;

    logic [bbr_pkg::SUM25_W-1:0] n_b_sum [3];
    logic [bbr_pkg::SUM25_W-1:0] r_b_sum [3];
    logic          r_b_valid, r_b_last;
    logic [CW-1:0] r_b_row, r_b_col;
    logic [bbr_pkg::PROD_W-1:0]  prod [3];
    t_res          res_in;

    // last row and column of the current run
    always_comb begin
        row_end = (r_job.row == r_job.row_last) ? r_job.row
                                                : r_job.row - CW'(bbr_pkg::KHALF);
        col_end = (r_job.col == r_job.col_last) ? r_job.col
                                                : r_job.col - CW'(bbr_pkg::KHALF);
        last_issue = (r_pos_r == row_end) && (r_pos_c == col_end);
    end

    // issue only when the queue has room for everything in flight
    assign issue   = r_active &&
                     ((r_cnt + bbr_pkg::CNT_W'(r_a_valid) + bbr_pkg::CNT_W'(r_b_valid))
                      < bbr_pkg::CNT_W'(bbr_pkg::FIFO_DEPTH));
    assign o_ready = !r_active || (issue && last_issue);

    // position sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_job_load) begin
            r_active <= 1'b1;
        end else if (issue && last_issue) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_load) begin
            r_job   <= i_job;
            r_pos_r <= i_job.row - CW'(bbr_pkg::KHALF);
            r_pos_c <= i_job.col - CW'(bbr_pkg::KHALF);
        end else if (issue && !last_issue) begin
            if (r_pos_c == col_end) begin
                r_pos_c <= r_job.col - CW'(bbr_pkg::KHALF);
                r_pos_r <= r_pos_r + CW'(1);
            end else begin
                r_pos_c <= r_pos_c + CW'(1);
            end
        end
    end

    // window indexes with border replication, then per-row sums
    always_comb begin
        logic [bbr_pkg::SUM5_W-1:0] acc;
        bbr_pkg::t_pix p;
        for (int d = 0; d < K; d++) begin
            wi[d] = bbr_pkg::win_idx(bbr_pkg::to_spos(r_pos_r) + bbr_pkg::t_spos'(d - 2),
                                     bbr_pkg::to_spos(r_job.row_last),
                                     bbr_pkg::to_spos(r_job.row));
            wj[d] = bbr_pkg::win_idx(bbr_pkg::to_spos(r_pos_c) + bbr_pkg::t_spos'(d - 2),
                                     bbr_pkg::to_spos(r_job.col_last),
                                     bbr_pkg::to_spos(r_job.col));
        end
        for (int d = 0; d < K; d++) begin
            for (int ch = 0; ch < 3; ch++) begin
                acc = '0;
                for (int x = 0; x < K; x++) begin
                    p   = i_win[wi[d]][wj[x]];
                    acc = acc + bbr_pkg::SUM5_W'(p[ch*CH +: CH]);
                end
                n_a_sum[d][ch] = acc;
            end
        end
    end

    // stage a: row sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= issue;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_sum  <= n_a_sum;
        r_a_row  <= r_pos_r;
        r_a_col  <= r_pos_c;
        r_a_last <= last_issue;
    end

    // stage b: full 25-sample sums
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_b_sum[ch] = '0;
            for (int d = 0; d < K; d++) begin
                n_b_sum[ch] = n_b_sum[ch] + bbr_pkg::SUM25_W'(r_a_sum[d][ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_sum  <= n_b_sum;
        r_b_row  <= r_a_row;
        r_b_col  <= r_a_col;
        r_b_last <= r_a_last;
    end

    // divide by 25 through the reciprocal, straight into the queue
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = bbr_pkg::PROD_W'(r_b_sum[ch]) *
                       bbr_pkg::PROD_W'(bbr_pkg::RECIP);
        end
        res_in.red   = prod[0][bbr_pkg::RECIP_SHIFT +: CH];
        res_in.green = prod[1][bbr_pkg::RECIP_SHIFT +: CH];
        res_in.blue  = prod[2][bbr_pkg::RECIP_SHIFT +: CH];
        res_in.row   = r_b_row[bbr_pkg::ROW_W-1:0];
        res_in.col   = r_b_col[COL_W-1:0];
        res_in.last  = r_b_last;
    end

    // result queue
    assign push        = r_b_valid;
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            if (push) r_wp <= r_wp + bbr_pkg::FIFO_AW'(1);
            if (pop)  r_rp <= r_rp + bbr_pkg::FIFO_AW'(1);
            r_cnt <= r_cnt + bbr_pkg::CNT_W'(push) - bbr_pkg::CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= res_in;
        end
    end

    assign o_red_out   = r_fifo[r_rp].red;
    assign o_green_out = r_fifo[r_rp].green;
    assign o_blue_out  = r_fifo[r_rp].blue;
    assign o_out_row   = r_fifo[r_rp].row;
    assign o_out_col   = r_fifo[r_rp].col;
    assign o_run_last  = r_fifo[r_rp].last;

endmodule

// ===== sv/box_blur_5x5_rgb.sv =====
// top level of the 5x5 rgb box blur with replicated borders
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------------
//  in       | in        | i_in_valid / o_in_stall | i_red_in i_green_in i_blue_in
//  out      | out       | o_out_valid / i_out_stall | o_red_out .. o_out_col o_run_last
//  cfg      | in        | i_cfg_we               | i_cfg_idx i_cfg_data
//
//  an item is registered in the front end and the sequencer issues one 25-sample
//  sum per cycle while the queue has room; an item releases 1 result inside,
//  3 at a row end and in the last row, 9 at the last pixel of the image.
//  the first result of an item passes the front-end register, the job register, stages a and b and the queue.
//  reset is synchronous; the line store is not cleared and needs no clearing pass.
//  the input stalls while the sequencer still has results of an earlier item to
//  issue; a stalled output holds in an 8-entry queue and stops issue once it and
//  the pipeline are full.
`timescale 1ns / 1ps
module box_blur_5x5_rgb #(
    parameter int MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bbr_pkg::CH_W-1:0]    i_red_in,
    input  logic [bbr_pkg::CH_W-1:0]    i_green_in,
    input  logic [bbr_pkg::CH_W-1:0]    i_blue_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bbr_pkg::CH_W-1:0]    o_red_out,
    output logic [bbr_pkg::CH_W-1:0]    o_green_out,
    output logic [bbr_pkg::CH_W-1:0]    o_blue_out,
    output logic [bbr_pkg::ROW_W-1:0]   o_out_row,
    output logic [COL_W-1:0]            o_out_col,
    output logic                        o_run_last,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [bbr_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int CW = bbr_pkg::CRD_W;

    logic [bbr_pkg::CFG_W-1:0] r_image_width, r_image_height;
    logic [CW-1:0]             w_eff, h_eff;
    bbr_pkg::t_pix             pix;
    bbr_pkg::t_win             win;
    bbr_pkg::t_job             job;
    logic                      job_load, gen_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bbr_pkg::CFG_W'(bbr_pkg::RST_WIDTH);
            r_image_height <= bbr_pkg::CFG_W'(bbr_pkg::RST_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (bbr_pkg::t_reg_idx'(i_cfg_idx))
                bbr_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                bbr_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
            endcase
        end
    end

    // effective geometry
    always_comb begin
        if (CW'(r_image_width) < CW'(bbr_pkg::MIN_DIM)) begin
            w_eff = CW'(bbr_pkg::MIN_DIM);
        end else if (CW'(r_image_width) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_image_width);
        end
        h_eff = (CW'(r_image_height) < CW'(bbr_pkg::MIN_DIM)) ? CW'(bbr_pkg::MIN_DIM)
                                                              : CW'(r_image_height);
    end

    assign pix = {i_blue_in, i_green_in, i_red_in};

    bbr_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_pix       (pix),
        .i_w_eff     (w_eff),
        .i_h_eff     (h_eff),
        .i_gen_ready (gen_ready),
        .o_win       (win),
        .o_job       (job),
        .o_job_load  (job_load)
    );

    bbr_gen #(
        .COL_W (COL_W)
    ) u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win       (win),
        .i_job       (job),
        .i_job_load  (job_load),
        .o_ready     (gen_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== sv/bbr_checker.sv =====
// port-level checks of the box blur, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [bbr_pkg::CH_W-1:0]  o_red_out,
    input logic [bbr_pkg::ROW_W-1:0] o_out_row,
    input logic                      o_run_last
);

    // a stalled result item stays offered
    `BBR_ASSERT_CLK(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "out valid dropped")

    // and keeps its red channel, row and run-last flag
    `BBR_ASSERT_CLK(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_red_out), "data moved")
    `BBR_ASSERT_CLK(a_row_stable, o_out_valid && i_out_stall |=> $stable(o_out_row), "row moved")
    `BBR_ASSERT_CLK(a_last_stable, o_out_valid && i_out_stall |=> $stable(o_run_last), "last moved")

    // reset empties the queue and frees the input
    `BBR_ASSERT_RST(a_rst_clear, !i_rst_n |=> !o_out_valid && !o_in_stall, "state after reset")

endmodule

bind box_blur_5x5_rgb bbr_checker u_bbr_checker (.*);

// ===== dv/bbr_blur_checker.sv =====
// checker for the 5x5 rgb box blur: watches the channels, predicts and compares results
`timescale 1ns / 1ps
module bbr_blur_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [7:0]                i_red_in,
    input  logic [7:0]                i_green_in,
    input  logic [7:0]                i_blue_in,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [7:0]                i_red_out,
    input  logic [7:0]                i_green_out,
    input  logic [7:0]                i_blue_out,
    input  logic [11:0]               i_out_row,
    input  logic [10:0]               i_out_col,
    input  logic                      i_run_last,
    input  logic                      i_cfg_we,
    input  bbr_pkg::t_reg_idx         i_cfg_idx,
    input  logic [11:0]               i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int LINE_DEPTH = 2048;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [10:0] col;
        logic        last;
    } t_blur_px;

    t_blur_px     blur_q[$];
    logic [23:0]  line_mem [0:4*LINE_DEPTH-1];
    logic [23:0]  win [0:4][0:4];
    int           next_col;
    int           next_row;
    logic [11:0]  width_reg;
    logic [11:0]  height_reg;
    int           errors;

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the image model by one pixel and queue the averages it releases
    task automatic blur_pixel(input logic [23:0] px);
        int w, h, c, r, rl, cl, rr, cc, dy, dx, wi, wj, k, j, nres, idx;
        int sr, sg, sb;
        logic [23:0] p;
        t_blur_px e;
        w = clip(int'(width_reg), 3, LINE_DEPTH);
        h = (height_reg < 3) ? 3 : int'(height_reg);
        if (next_col >= w) next_col = w - 1;
        if (next_row >= h) next_row = h - 1;
        c = next_col;
        r = next_row;

        // shift window left, pull the column from the line store
        for (k = 0; k < 5; k++)
            for (j = 0; j < 4; j++)
                win[k][j] = win[k][j+1];
        for (k = 0; k < 4; k++)
            win[k][4] = (r + k >= 4) ? line_mem[((r + k) & 3) * LINE_DEPTH + c] : 24'd0;
        win[4][4] = px;
        line_mem[(r & 3) * LINE_DEPTH + c] = px;

        // centre lags two rows and two columns; edges release the rest
        if (r >= 2 && c >= 2) begin
            rl = (r == h - 1) ? r : r - 2;
            cl = (c == w - 1) ? c : c - 2;
            nres = (rl - r + 3) * (cl - c + 3);
            idx = 0;
            for (rr = r - 2; rr <= rl; rr++) begin
                for (cc = c - 2; cc <= cl; cc++) begin
                    sr = 0;
                    sg = 0;
                    sb = 0;
                    for (dy = -2; dy <= 2; dy++) begin
                        wi = clip(clip(rr + dy, 0, h - 1) - r + 4, 0, 4);
                        for (dx = -2; dx <= 2; dx++) begin
                            wj = clip(clip(cc + dx, 0, w - 1) - c + 4, 0, 4);
                            p = win[wi][wj];
                            sr += p[7:0];
                            sg += p[15:8];
                            sb += p[23:16];
                        end
                    end
                    e.red   = 8'(sr / 25);
                    e.green = 8'(sg / 25);
                    e.blue  = 8'(sb / 25);
                    e.row   = 12'(rr);
                    e.col   = 11'(cc);
                    e.last  = (idx == nres - 1);
                    blur_q.push_back(e);
                    idx++;
                end
            end
        end

        // raster position of the next pixel
        if (next_col >= w - 1) begin
            next_col = 0;
            next_row = (next_row >= h - 1) ? 0 : next_row + 1;
        end else begin
            next_col = next_col + 1;
        end
    endtask

    // compare one observed result with the oldest expected one
    task automatic check_result();
        t_blur_px e;
        if (blur_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result row %0d col %0d rgb %0d %0d %0d",
                         i_out_row, i_out_col, i_red_out, i_green_out, i_blue_out);
        end else begin
            e = blur_q.pop_front();
            if (e.red !== i_red_out || e.green !== i_green_out || e.blue !== i_blue_out ||
                e.row !== i_out_row || e.col !== i_out_col || e.last !== i_run_last) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp r%0d c%0d rgb %0d %0d %0d last %0d, ",
                              "got r%0d c%0d rgb %0d %0d %0d last %0d"},
                             e.row, e.col, e.red, e.green, e.blue, e.last,
                             i_out_row, i_out_col, i_red_out, i_green_out, i_blue_out,
                             i_run_last);
            end
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blur_q.delete();
            for (int k = 0; k < 5; k++)
                for (int j = 0; j < 5; j++)
                    win[k][j] = 24'd0;
            next_col = 0;
            next_row = 0;
            width_reg = 12'(bbr_pkg::RST_WIDTH);
            height_reg = 12'(bbr_pkg::RST_HEIGHT);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bbr_pkg::REG_IMAGE_WIDTH:  width_reg = i_cfg_data;
                    bbr_pkg::REG_IMAGE_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_in_valid && !i_in_stall)
                blur_pixel({i_blue_in, i_green_in, i_red_in});
        end
        o_pending <= blur_q.size();
        o_fail_count <= errors;
    end

    initial begin
        errors = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

endmodule

// ===== dv/tb_box_blur_5x5_rgb.sv =====
// testbench top of the 5x5 rgb box blur: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_box_blur_5x5_rgb;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [7:0]        i_red_in;
    logic [7:0]        i_green_in;
    logic [7:0]        i_blue_in;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [7:0]        o_red_out;
    logic [7:0]        o_green_out;
    logic [7:0]        o_blue_out;
    logic [11:0]       o_out_row;
    logic [10:0]       o_out_col;
    logic              o_run_last;
    logic              i_cfg_we;
    bbr_pkg::t_reg_idx i_cfg_idx;
    logic [11:0]       i_cfg_data;
    int                fail_count;
    int                pending;
    int                cycles;
    int                stall_left;
    logic              quiet;
    int                rand_pixels;

    box_blur_5x5_rgb u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_red_in(i_red_in), .i_green_in(i_green_in), .i_blue_in(i_blue_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_red_out(o_red_out), .o_green_out(o_green_out), .o_blue_out(o_blue_out),
        .o_out_row(o_out_row), .o_out_col(o_out_col), .o_run_last(o_run_last),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    bbr_blur_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_red_in(i_red_in), .i_green_in(i_green_in), .i_blue_in(i_blue_in),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_red_out(o_red_out), .i_green_out(o_green_out), .i_blue_out(o_blue_out),
        .i_out_row(o_out_row), .i_out_col(o_out_col), .i_run_last(o_run_last),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output stall in random bursts, no new bursts once quiet
    initial begin
        i_out_stall = 1'b0;
        stall_left = 0;
    end
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // one pixel item, with an occasional gap before it
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red_in <= r;
        i_green_in <= g;
        i_blue_in <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan());
    endtask

    // hold the input until every expected result is out, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input bbr_pkg::t_reg_idx idx, input logic [11:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [11:0] w, input logic [11:0] h);
        write_reg(bbr_pkg::REG_IMAGE_WIDTH, w);
        write_reg(bbr_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    initial begin
        int w, h;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_red_in = 8'd0;
        i_green_in = 8'd0;
        i_blue_in = 8'd0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bbr_pkg::REG_IMAGE_WIDTH;
        i_cfg_data = 12'd0;
        quiet = 1'b0;
        rand_pixels = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest image from out-of-range registers, extreme pixel values
        set_geometry(12'd0, 12'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        // back-to-back image with the same geometry
        for (int i = 0; i < 9; i++)
            send_pixel(8'd255, 8'd255, 8'd255);
        drain();

        // width 2 still acts as 3
        set_geometry(12'd2, 12'd3);
        send_random(9);
        drain();

        // height far beyond the rows sent, then shrunk mid-image: row saturates
        set_geometry(12'd6, 12'd4095);
        send_random(36);
        drain();
        write_reg(bbr_pkg::REG_IMAGE_HEIGHT, 12'd4);
        send_random(6);
        drain();

        // width shrunk mid-row: column saturates
        set_geometry(12'd10, 12'd8);
        send_random(57);
        drain();
        write_reg(bbr_pkg::REG_IMAGE_WIDTH, 12'd5);
        send_random(3 + 5 * 2);
        drain();

        // random small images, the last ones without idling
        while (rand_pixels < 90) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
            set_geometry(12'(w), 12'(h));
            w = (w < 3) ? 3 : w;
            h = (h < 3) ? 3 : h;
            if (rand_pixels > 50)
                quiet = 1'b1;
            send_random(w * h);
            rand_pixels += w * h;
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bbr_pkg.sv
sv/bbr_line_mem.sv
sv/bbr_front.sv
sv/bbr_gen.sv
sv/box_blur_5x5_rgb.sv
sv/bbr_checker.sv
dv/bbr_blur_checker.sv
dv/tb_box_blur_5x5_rgb.sv
